// ===== rtl/core/glmt_pkg.sv =====
`timescale 1ns / 1ps

package glmt_pkg;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_GROUP_ID = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT  = 1'b1;

  localparam logic [2:0] REQ_HEARTBEAT = 3'd0;
  localparam logic [2:0] REQ_JOIN      = 3'd1;
  localparam logic [2:0] REQ_LEAVE     = 3'd2;
  localparam logic [2:0] REQ_TICK      = 3'd3;

  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_MEMBER = 2'd2;

  localparam logic [3:0] ST_ACCEPT      = 4'd0;
  localparam logic [3:0] ST_REJECT_DUP  = 4'd1;
  localparam logic [3:0] ST_REJECT_FULL = 4'd2;
  localparam logic [3:0] ST_REFRESHED   = 4'd3;
  localparam logic [3:0] ST_LEFT        = 4'd4;
  localparam logic [3:0] ST_WRONG_GROUP = 4'd5;
  localparam logic [3:0] ST_UNKNOWN     = 4'd6;
  localparam logic [3:0] ST_IDLE_IGN    = 4'd7;
  localparam logic [3:0] ST_INVALID     = 4'd8;

  localparam logic [7:0] TIMEOUT_RESET = 8'd20;

  typedef struct packed {
    logic       capture;
    logic       start_group;
    logic       scan_start;
    logic       scan_step;
    logic       add;
    logic       refresh;
    logic       remove;
    logic       load_reply;
    logic [3:0] reply_status;
    logic       load_header;
    logic       emit_step;
    logic       load_member;
  } glmt_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       running;
    logic       group_match;
    logic       scan_done;
    logic       found;
    logic       free_found;
    logic       alive_zero;
    logic       slot_hit;
    logic       emit_last;
    logic       out_free;
  } glmt_stat_t;

endpackage

// ===== rtl/core/glmt_in_if.sv =====
`timescale 1ns / 1ps

interface glmt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] sender_id;
  logic [31:0] msg_group_id;

  modport source (output valid, output req_type, output sender_id, output msg_group_id,
                  input ready);
  modport sink (input valid, input req_type, input sender_id, input msg_group_id,
                output ready);
endinterface

// ===== rtl/core/glmt_out_if.sv =====
`timescale 1ns / 1ps

interface glmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [3:0]  status;
  logic [31:0] reply_dest;
  logic [31:0] member_id;
  logic [4:0]  member_count;
  logic [4:0]  dropped_count;
  logic        last;

  modport source (output valid, output item_kind, output status, output reply_dest,
                  output member_id, output member_count, output dropped_count,
                  output last, input ready);
  modport sink (input valid, input item_kind, input status, input reply_dest,
                input member_id, input member_count, input dropped_count,
                input last, output ready);
endinterface

// ===== rtl/core/glmt_ram.sv =====
`timescale 1ns / 1ps

module glmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/glmt_dp.sv =====
`timescale 1ns / 1ps

module glmt_dp import glmt_pkg::*; #(
  parameter int MAX_MEMBERS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [2:0]            in_req_type,
  input  logic [31:0]           in_sender_id,
  input  logic [31:0]           in_msg_group_id,
  input  logic                  out_ready,
  input  glmt_cmd_t             cmd,
  output glmt_stat_t            stat,
  output logic                  out_valid,
  output logic [1:0]            out_item_kind,
  output logic [3:0]            out_status,
  output logic [31:0]           out_reply_dest,
  output logic [31:0]           out_member_id,
  output logic [4:0]            out_member_count,
  output logic [4:0]            out_dropped_count,
  output logic                  out_last
);

  localparam int IDX_W = $clog2(MAX_MEMBERS);
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
  localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(MAX_MEMBERS);

  logic [2:0]             cur_type;
  logic [31:0]            cur_sender;
  logic [31:0]            cur_group;
  logic [31:0]            group_id;
  logic [7:0]             hb_timeout;
  logic                   running;
  logic [MAX_MEMBERS-1:0] valid;
  logic [CNT_W-1:0]       idx;
  logic [CNT_W-1:0]       alive;
  logic [CNT_W-1:0]       dropped;
  logic [CNT_W-1:0]       emit_cnt;
  logic                   chk_vld;
  logic [IDX_W-1:0]       chk_idx;
  logic [IDX_W-1:0]       found_idx;
  logic [IDX_W-1:0]       free_idx;
  logic                   found;
  logic                   free_found;

  logic [IDX_W-1:0] idx_lo;
  logic             rd_en;
  logic [31:0]      mem_rd;
  logic [7:0]       age_rd;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             age_we;
  logic [IDX_W-1:0] age_waddr;
  logic [7:0]       age_wdata;
  logic             chk_go;
  logic             is_tick;
  logic             age_slot;
  logic [7:0]       age_inc;
  logic             expired;
  logic             emit_last;

  assign idx_lo    = idx[IDX_W-1:0];
  assign is_tick   = (cur_type == REQ_TICK);
  assign chk_go    = cmd.scan_step && chk_vld;
  assign age_slot  = chk_go && is_tick && valid[chk_idx];
  assign age_inc   = (age_rd == 8'hFF) ? age_rd : age_rd + 8'd1;
  assign expired   = (age_inc >= hb_timeout);
  assign emit_last = ((emit_cnt + CNT_W'(1)) == alive);
  assign rd_en     = (cmd.scan_step && (idx != SLOT_END)) ||
                     (cmd.emit_step && valid[idx_lo]);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    if (cmd.start_group) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
    end else if (cmd.add) begin
      mem_we    = 1'b1;
      mem_waddr = free_idx;
    end
  end

  always_comb begin
    age_we    = 1'b0;
    age_waddr = chk_idx;
    age_wdata = 8'd0;
    if (age_slot) begin
      age_we    = 1'b1;
      age_wdata = age_inc;
    end else if (cmd.add) begin
      age_we    = 1'b1;
      age_waddr = free_idx;
    end else if (cmd.refresh) begin
      age_we    = 1'b1;
      age_waddr = found_idx;
    end else if (cmd.start_group) begin
      age_we    = 1'b1;
      age_waddr = '0;
    end
  end

  glmt_ram #(.WIDTH(32), .DEPTH(MAX_MEMBERS)) u_member_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (cur_sender),
    .re    (rd_en),
    .raddr (idx_lo),
    .rdata (mem_rd)
  );

  glmt_ram #(.WIDTH(8), .DEPTH(MAX_MEMBERS)) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_wdata),
    .re    (rd_en),
    .raddr (idx_lo),
    .rdata (age_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      group_id   <= '0;
      hb_timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GROUP_ID: group_id <= cfg_wdata;
        REG_TIMEOUT:  hb_timeout <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_type   <= in_req_type;
      cur_sender <= in_sender_id;
      cur_group  <= in_msg_group_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      valid   <= '0;
    end else begin
      if (cmd.start_group) begin
        running <= 1'b1;
        valid   <= {{(MAX_MEMBERS-1){1'b0}}, 1'b1};
      end
      if (age_slot && expired) begin
        valid[chk_idx] <= 1'b0;
      end
      if (cmd.add) begin
        valid[free_idx] <= 1'b1;
      end
      if (cmd.remove) begin
        valid[found_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else if (cmd.scan_start) begin
      chk_vld <= 1'b0;
    end else if (cmd.scan_step) begin
      chk_vld <= (idx != SLOT_END);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      alive      <= '0;
      dropped    <= '0;
    end else begin
      if (cmd.scan_step && (idx != SLOT_END)) begin
        idx     <= idx + CNT_W'(1);
        chk_idx <= idx_lo;
      end
      if (chk_go) begin
        if (valid[chk_idx] && (mem_rd == cur_sender) && !found) begin
          found     <= 1'b1;
          found_idx <= chk_idx;
        end
        if (!valid[chk_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
      end
      if (age_slot) begin
        if (expired) begin
          dropped <= dropped + CNT_W'(1);
        end else begin
          alive <= alive + CNT_W'(1);
        end
      end
      if (cmd.load_header) begin
        idx      <= '0;
        emit_cnt <= '0;
      end
      if (cmd.emit_step) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.load_member) begin
        emit_cnt <= emit_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_reply || cmd.load_header || cmd.load_member) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_reply) begin
      out_item_kind     <= KIND_REPLY;
      out_status        <= cmd.reply_status;
      out_reply_dest    <= cur_sender;
      out_member_id     <= '0;
      out_member_count  <= '0;
      out_dropped_count <= '0;
      out_last          <= 1'b1;
    end else if (cmd.load_header) begin
      out_item_kind     <= KIND_HEADER;
      out_status        <= ST_ACCEPT;
      out_reply_dest    <= '0;
      out_member_id     <= '0;
      out_member_count  <= 5'(alive);
      out_dropped_count <= 5'(dropped);
      out_last          <= (alive == '0);
    end else if (cmd.load_member) begin
      out_item_kind     <= KIND_MEMBER;
      out_status        <= ST_ACCEPT;
      out_reply_dest    <= '0;
      out_member_id     <= mem_rd;
      out_member_count  <= '0;
      out_dropped_count <= '0;
      out_last          <= emit_last;
    end
  end

  always_comb begin
    stat.req_type    = cur_type;
    stat.running     = running;
    stat.group_match = (cur_group == group_id);
    stat.scan_done   = (idx == SLOT_END) && !chk_vld;
    stat.found       = found;
    stat.free_found  = free_found;
    stat.alive_zero  = (alive == '0);
    stat.slot_hit    = valid[idx_lo];
    stat.emit_last   = emit_last;
    stat.out_free    = !out_valid || out_ready;
  end

endmodule

// ===== rtl/core/glmt_ctrl.sv =====
`timescale 1ns / 1ps

module glmt_ctrl import glmt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  glmt_stat_t stat,
  output glmt_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_DISPATCH  = 8'b0000_0010,
    S_FIND      = 8'b0000_0100,
    S_AGE       = 8'b0000_1000,
    S_REPLY     = 8'b0001_0000,
    S_HEAD      = 8'b0010_0000,
    S_EMIT_SEEK = 8'b0100_0000,
    S_EMIT_OUT  = 8'b1000_0000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [3:0] st;
  logic [3:0] st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    st <= st_next;
  end

  always_comb begin
    state_next = state;
    st_next    = st;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.req_type)
          REQ_JOIN: begin
            if (!stat.running) begin
              cmd.start_group = 1'b1;
              st_next         = ST_ACCEPT;
              state_next      = S_REPLY;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_FIND;
            end
          end
          REQ_HEARTBEAT, REQ_LEAVE: begin
            if (!stat.running) begin
              st_next    = ST_IDLE_IGN;
              state_next = S_REPLY;
            end else if (!stat.group_match) begin
              st_next    = ST_WRONG_GROUP;
              state_next = S_REPLY;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_FIND;
            end
          end
          REQ_TICK: begin
            if (!stat.running) begin
              st_next    = ST_IDLE_IGN;
              state_next = S_REPLY;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_AGE;
            end
          end
          default: begin
            st_next    = ST_INVALID;
            state_next = S_REPLY;
          end
        endcase
      end
      S_FIND: begin
        if (!stat.scan_done) begin
          cmd.scan_step = 1'b1;
        end else begin
          state_next = S_REPLY;
          case (stat.req_type)
            REQ_JOIN: begin
              if (stat.found) begin
                st_next = ST_REJECT_DUP;
              end else if (stat.free_found) begin
                cmd.add = 1'b1;
                st_next = ST_ACCEPT;
              end else begin
                st_next = ST_REJECT_FULL;
              end
            end
            REQ_HEARTBEAT: begin
              if (stat.found) begin
                cmd.refresh = 1'b1;
                st_next     = ST_REFRESHED;
              end else begin
                st_next = ST_UNKNOWN;
              end
            end
            default: begin
              if (stat.found) begin
                cmd.remove = 1'b1;
                st_next    = ST_LEFT;
              end else begin
                st_next = ST_UNKNOWN;
              end
            end
          endcase
        end
      end
      S_AGE: begin
        if (!stat.scan_done) begin
          cmd.scan_step = 1'b1;
        end else begin
          state_next = S_HEAD;
        end
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.load_reply   = 1'b1;
          cmd.reply_status = st;
          state_next       = S_IDLE;
        end
      end
      S_HEAD: begin
        if (stat.out_free) begin
          cmd.load_header = 1'b1;
          state_next      = stat.alive_zero ? S_IDLE : S_EMIT_SEEK;
        end
      end
      S_EMIT_SEEK: begin
        cmd.emit_step = 1'b1;
        if (stat.slot_hit) begin
          state_next = S_EMIT_OUT;
        end
      end
      S_EMIT_OUT: begin
        if (stat.out_free) begin
          cmd.load_member = 1'b1;
          state_next      = stat.emit_last ? S_IDLE : S_EMIT_SEEK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/group_leader_membership_table.sv =====
`timescale 1ns / 1ps
// Leader-side group membership table.
// Messages enter on the req channel and result items leave on the rsp channel; both use a
// valid/ready handshake and an item moves when valid and ready are high at a clock edge.
// Every message except a tick of a running group gives one status reply. Such a tick gives
// a header followed by one item per surviving member in slot order; last marks the final item.
// The block takes one message at a time. An invalid message, a message to an idle group, a
// heartbeat or leave for another group and a join that starts the group go straight to their
// reply without a table search. Heartbeat and leave for this group and join to a running group
// search the whole table through the member memory, one slot per cycle, and then reply. A tick
// ages the table the same way, sends the header, then walks the slots again and sends one item
// per surviving member. The next message is taken as soon as the last item of the previous one
// sits in the output register.
// Reset empties the table, stops the group, sets group_id to 0 and the timeout to 20 ticks.
// The configuration port is to be written by the user only between messages; the block itself does not enforce this.
// When the receiver holds rsp.ready low, the output register keeps its item and the
// block waits.

module group_leader_membership_table import glmt_pkg::*; #(
  parameter int MAX_MEMBERS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  glmt_in_if.sink               req,
  glmt_out_if.source            rsp
);

  glmt_cmd_t  cmd;
  glmt_stat_t stat;

  glmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  glmt_dp #(.MAX_MEMBERS(MAX_MEMBERS)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_req_type       (req.req_type),
    .in_sender_id      (req.sender_id),
    .in_msg_group_id   (req.msg_group_id),
    .out_ready         (rsp.ready),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (rsp.valid),
    .out_item_kind     (rsp.item_kind),
    .out_status        (rsp.status),
    .out_reply_dest    (rsp.reply_dest),
    .out_member_id     (rsp.member_id),
    .out_member_count  (rsp.member_count),
    .out_dropped_count (rsp.dropped_count),
    .out_last          (rsp.last)
  );

endmodule
